/* rtl/core/ftpd_pkg.sv */
`timescale 1ns / 1ps

package ftpd_pkg;

  localparam int TableEntries   = 16;
  localparam int MaxPrefixBytes = 10;
  localparam int IdxW           = $clog2(TableEntries);
  localparam int CntW           = $clog2(TableEntries + 1);
  localparam int PatW           = 80;
  localparam int FrameW         = 112;
  localparam int InW            = 208;
  localparam int OutW           = 16;
  localparam logic [15:0] EtherIIMin = 16'd1536;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_LOOKUP = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_TOO_LONG  = 3'd2,
    STATUS_DUPLICATE = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ftpd_cmd_t;

  function automatic logic [PatW-1:0] prefix_mask(input logic [3:0] len);
    logic [PatW-1:0] m;
    m = '0;
    for (int b = 0; b < PatW / 8; b++) begin
      m[8*b +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

/* rtl/core/ftpd_ctrl.sv */
`timescale 1ns / 1ps

module ftpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output ftpd_pkg::ftpd_cmd_t cmd
);
  import ftpd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  assign s_tready    = (state == ST_IDLE);
  assign m_tvalid    = out_valid;
  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.execute = (state == ST_EXEC) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd.execute) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/core/ftpd_dp.sv */
`timescale 1ns / 1ps

module ftpd_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  ftpd_pkg::ftpd_cmd_t       cmd,
  input  logic [ftpd_pkg::InW-1:0]  in_data,
  output logic [ftpd_pkg::OutW-1:0] out_data
);
  import ftpd_pkg::*;

  logic [1:0]        in_mode;
  logic [3:0]        in_handle;
  logic [3:0]        in_len;
  logic [PatW-1:0]   in_type;
  logic [FrameW-1:0] in_frame;

  logic [3:0]      ent_handle [TableEntries];
  logic [3:0]      ent_len    [TableEntries];
  logic [PatW-1:0] ent_pat    [TableEntries];
  logic [CntW-1:0] count, count_next;

  logic [2:0] res_status;
  logic [3:0] res_found;
  logic [4:0] res_count;

  logic [TableEntries-1:0] valid, hit_handle, dup_pat, lk;
  logic [TableEntries-1:0] first_lk, first_rm, ge_rm;
  logic [PatW-1:0]         new_pat, win;
  logic [15:0]             type_word;
  logic                    too_long, full, do_insert, do_remove;
  logic [2:0]              status_c;
  logic [3:0]              found_c;
  logic [CntW+4:0]         count_ext;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_mode   <= in_data[1:0];
      in_handle <= in_data[5:2];
      in_len    <= in_data[9:6];
      in_type   <= in_data[89:10];
      in_frame  <= in_data[201:90];
    end
  end

  assign new_pat   = in_type & prefix_mask(in_len);
  assign type_word = {in_frame[7:0], in_frame[15:8]};
  assign win       = (type_word >= EtherIIMin) ? in_frame[PatW-1:0] : in_frame[PatW+15:16];
  assign too_long  = in_len > 4'(MaxPrefixBytes);
  assign full      = (count == CntW'(TableEntries));

  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      valid[i]      = CntW'(i) < count;
      hit_handle[i] = valid[i] && (ent_handle[i] == in_handle);
      dup_pat[i]    = valid[i] && (ent_len[i] > 4'd1) &&
                      (((ent_pat[i] ^ new_pat) & prefix_mask(ent_len[i])) == '0);
      lk[i]         = valid[i] && ((ent_len[i] < 4'd2) ||
                      (((ent_pat[i] ^ win) & prefix_mask(ent_len[i])) == '0));
    end
  end

  assign first_lk = lk & (~lk + 1'b1);
  assign first_rm = hit_handle & (~hit_handle + 1'b1);
  assign ge_rm    = ~(first_rm - 1'b1);

  always_comb begin
    found_c = '0;
    for (int i = 0; i < TableEntries; i++) begin
      found_c = found_c | (first_lk[i] ? ent_handle[i] : 4'd0);
    end
  end

  always_comb begin
    status_c   = STATUS_OK;
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    count_next = count;
    unique case (in_mode)
      MODE_INSERT: begin
        if (too_long) begin
          status_c = STATUS_TOO_LONG;
        end else if (full) begin
          status_c = STATUS_FULL;
        end else if ((|hit_handle) || (|dup_pat)) begin
          status_c = STATUS_DUPLICATE;
        end else begin
          do_insert  = 1'b1;
          count_next = count + 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (|hit_handle) begin
          do_remove  = 1'b1;
          count_next = count - 1'b1;
        end else begin
          status_c = STATUS_NOT_FOUND;
        end
      end
      MODE_LOOKUP: begin
        if (!(|lk)) begin
          status_c = STATUS_NOT_FOUND;
        end
      end
      default: status_c = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (do_insert) begin
        ent_handle[count[IdxW-1:0]] <= in_handle;
        ent_len[count[IdxW-1:0]]    <= in_len;
        ent_pat[count[IdxW-1:0]]    <= new_pat;
      end
      if (do_remove) begin
        for (int i = 0; i < TableEntries - 1; i++) begin
          if (ge_rm[i]) begin
            ent_handle[i] <= ent_handle[i+1];
            ent_len[i]    <= ent_len[i+1];
            ent_pat[i]    <= ent_pat[i+1];
          end
        end
      end
    end
  end

  assign count_ext = {5'd0, count_next};

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_status <= status_c;
      res_found  <= (in_mode == MODE_LOOKUP) ? found_c : 4'd0;
      res_count  <= count_ext[4:0];
    end
  end

  assign out_data = {4'd0, res_count, res_found, res_status};

endmodule

/* rtl/core/frame_type_prefix_demux_table.sv */
`timescale 1ns / 1ps
// Channel  Direction  Width  Fields (lowest bit first)
// s_*      in         208    mode 2, handle_id 4, type_len 4, type_bytes_low 64,
//                            type_bytes_high 16, frame_bytes_low 64, frame_bytes_high 48
// m_*      out        16     status 3, found_handle 4, entries_used 5
//
// Each operation has two steps: one registers the transfer, the other does the
// parallel compare of all table entries and the table update.
// Reset clears the entry count and the control state; table contents are never cleared.
// A result waiting on m_tready holds the block in its execute step; the
// input side is ready again as soon as the result is registered.

module frame_type_prefix_demux_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ftpd_pkg::InW-1:0]  s_tdata,  // mode, handle_id, type_len, type_bytes_low,
                                              // type_bytes_high, frame_bytes_low,
                                              // frame_bytes_high, zero pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ftpd_pkg::OutW-1:0] m_tdata   // status, found_handle, entries_used, zero pad
);
  import ftpd_pkg::*;

  ftpd_cmd_t cmd;

  ftpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  ftpd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule

/* rtl/core/ftpd_checker.sv */
`timescale 1ns / 1ps

module ftpd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [ftpd_pkg::OutW-1:0] m_tdata
);
  import ftpd_pkg::*;

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
    else $error("result missing two cycles after an idle-side transfer");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= STATUS_NOT_FOUND) && (m_tdata[15:12] == 4'd0) &&
                 (m_tdata[11:7] <= 5'(TableEntries)))
    else $error("result fields out of range");

endmodule

bind frame_type_prefix_demux_table ftpd_checker u_checker (.*);
